// File: hw/rtl/somr_pkg.sv
// shared types and constants for the symmetry orbit minimum block
`timescale 1ns / 1ps
`default_nettype none
package somr_pkg;
   localparam int MaxSites  = 64;
   localparam int MaxSyms   = 32;
   localparam int SiteW     = 6;
   localparam int SymW      = 5;
   localparam int CountW    = 6;
   localparam int StateW    = 64;
   localparam int PermDepth = MaxSyms * MaxSites;
   localparam int PermAddrW = SymW + SiteW;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_SITE_COUNT = 1'b0;
   localparam logic CSR_SYM_COUNT  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [SymW-1:0]   sym_slot;
      logic [SiteW-1:0]  source_site;
      logic [SiteW-1:0]  target_site;
      logic [StateW-1:0] state_bits;
   } req_type;

   typedef struct packed {
      logic [StateW-1:0] representative;
      logic [SymW-1:0]   sym_index;
      logic [CountW-1:0] tie_count;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMPARE,
      ST_EMIT
   } state_type;

   // one memory read per cycle; this is the sequencer's view of the permutation accumulator
   typedef struct packed {
      logic clear;
      logic fold;
   } perm_ctl_type;
endpackage
`default_nettype wire

// File: hw/rtl/somr_perm_unit.sv
// shared permutation accumulator: ORs one moved bit into the permuted word per cycle while fold is set
`timescale 1ns / 1ps
`default_nettype none
module somr_perm_unit (
   input  wire logic                          clock,
   input  wire somr_pkg::perm_ctl_type        ctl,
   input  wire logic                          bit_value,
   input  wire logic [somr_pkg::SiteW-1:0]    target,
   output logic      [somr_pkg::StateW-1:0]   acc
);
   import somr_pkg::*;
   logic [StateW-1:0] acc_ff, acc_in, base;

   always_comb begin
      base   = ctl.clear ? '0 : acc_ff;
      acc_in = base;
      if (ctl.fold && bit_value) acc_in[target] = 1'b1;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

// File: hw/rtl/symmetry_orbit_min_representative.sv
// top level: orbit minimum over loaded bit permutations, one table read per cycle
// per query: scan, drain and compare for each symmetry, then one
//   result per tied symmetry (a single result when nsyms is 0)
// throughput: one item at a time, busy is high from accept until the last result
// the single table read port (one site per cycle) sets the scan length
// reset: synchronous active high; site_count 64, sym_count 0; table undefined until written
`timescale 1ns / 1ps
`default_nettype none
module symmetry_orbit_min_representative (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire somr_pkg::req_type      req_word,
   output logic                        rsp_strobe,
   output somr_pkg::rsp_type           rsp_word,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [0:0]             csr_index,
   input  wire logic [63:0]            csr_data
);
   import somr_pkg::*;

   // config registers, saturated on use
   logic [6:0] site_count_ff, site_count_in;
   logic [5:0] sym_count_ff, sym_count_in;
   logic [6:0] nsites;
   logic [5:0] nsyms;

   // sequencer state
   state_type         state_ff, state_in;
   logic [SymW:0]     sym_ff, sym_in;      // current symmetry, one extra bit for end
   logic [SiteW:0]    site_ff, site_in;    // sites issued to memory
   logic [StateW-1:0] bits_ff, bits_in;
   logic [StateW-1:0] best_ff, best_in;
   logic [CountW-1:0] ties_ff, ties_in;
   logic [CountW-1:0] emit_ff, emit_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [SiteW-1:0]  rd_site_ff, rd_site_in;

   // permutation table and tie list
   logic [SiteW-1:0] perm_mem [PermDepth];
   logic [SiteW-1:0] perm_rd_ff;
   logic [SymW-1:0]  tie_mem [MaxSyms];
   logic [SymW-1:0]  tie_rd_ff;

   logic             accept;
   logic             mem_we, rd_en, tie_we;
   logic [PermAddrW-1:0] wr_addr, rd_addr;
   logic [SymW-1:0]  tie_waddr, tie_raddr, tie_wdata;
   perm_ctl_type     pctl;
   logic [StateW-1:0] perm_val;
   logic             v_less, v_equal;

   assign nsites = (site_count_ff > 7'(MaxSites)) ? 7'(MaxSites) : site_count_ff;
   assign nsyms  = (sym_count_ff > 6'(MaxSyms)) ? 6'(MaxSyms) : sym_count_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // config write
   always_comb begin
      site_count_in = site_count_ff;
      sym_count_in  = sym_count_ff;
      if (csr_valid) begin
         case (csr_index[0])
            CSR_SITE_COUNT: site_count_in = csr_data[6:0];
            CSR_SYM_COUNT:  sym_count_in  = csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= 7'd64;
         sym_count_ff  <= '0;
      end else begin
         site_count_ff <= site_count_in;
         sym_count_ff  <= sym_count_in;
      end
   end

   // shared unit; pipeline: address issue, registered read, fold
   somr_perm_unit u_perm (
      .clock     (clock),
      .ctl       (pctl),
      .bit_value (bits_ff[rd_site_ff]),
      .target    (perm_rd_ff),
      .acc       (perm_val)
   );

   assign v_less  = perm_val < best_ff;
   assign v_equal = perm_val == best_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.command == CMD_QUERY)
               state_in = (nsyms == '0) ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN:    if (7'(site_ff) + 7'd1 >= nsites) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_COMPARE;
         ST_COMPARE: state_in = (6'(sym_ff) + 6'd1 >= nsyms) ? ST_EMIT : ST_SCAN;
         ST_EMIT:    if (emit_ff + 6'd1 >= ties_ff || ties_ff == '0) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      sym_in      = sym_ff;
      site_in     = site_ff;
      bits_in     = bits_ff;
      best_in     = best_ff;
      ties_in     = ties_ff;
      emit_in     = emit_ff;
      rd_en       = 1'b0;
      rd_site_in  = site_ff[SiteW-1:0];
      rd_valid_in = 1'b0;
      pctl.clear  = 1'b0;
      pctl.fold   = rd_valid_ff;
      tie_we      = 1'b0;
      tie_waddr   = ties_ff[SymW-1:0];
      tie_wdata   = sym_ff[SymW-1:0];
      tie_raddr   = emit_ff[SymW-1:0];
      mem_we      = accept && req_word.command == CMD_WRITE;
      case (state_ff)
         ST_IDLE: begin
            pctl.clear = 1'b1;
            pctl.fold  = 1'b0;
            if (accept) begin
               bits_in = req_word.state_bits;
               sym_in  = '0;
               site_in = '0;
               best_in = '1;
               ties_in = '0;
               emit_in = '0;
            end
         end
         ST_SCAN: begin
            // nsites of zero: issue nothing, value stays 0
            rd_en       = (7'(site_ff) < nsites);
            rd_valid_in = rd_en;
            site_in     = site_ff + 7'd1;
         end
         ST_DRAIN: ;
         ST_COMPARE: begin
            pctl.clear = 1'b1;
            pctl.fold  = 1'b0;
            if (v_less) begin
               best_in   = perm_val;
               tie_waddr = '0;
               tie_we    = 1'b1;
               ties_in   = 6'd1;
            end else if (v_equal) begin
               tie_we  = 1'b1;
               ties_in = ties_ff + 6'd1;
            end
            sym_in  = sym_ff + 6'd1;
            site_in = '0;
            // first emit read issued next: keep tie read address at 0
            tie_raddr = '0;
         end
         ST_EMIT: begin
            emit_in   = emit_ff + 6'd1;
            tie_raddr = 5'(emit_ff + 6'd1);
         end
         default: ;
      endcase
   end

   assign wr_addr = {req_word.sym_slot, req_word.source_site};
   assign rd_addr = {sym_ff[SymW-1:0], site_ff[SiteW-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) perm_mem[wr_addr] <= req_word.target_site;
      if (rd_en)  perm_rd_ff <= perm_mem[rd_addr];
   end

   // tie list written during compare, read ahead one step during emit
   always_ff @(posedge clock) begin
      if (tie_we) tie_mem[tie_waddr] <= tie_wdata;
      tie_rd_ff <= (tie_we && tie_waddr == tie_raddr) ? tie_wdata : tie_mem[tie_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      sym_ff     <= sym_in;
      site_ff    <= site_in;
      bits_ff    <= bits_in;
      best_ff    <= best_in;
      ties_ff    <= ties_in;
      emit_ff    <= emit_in;
      rd_site_ff <= rd_site_in;
   end

   // result word
   always_comb begin
      rsp_strobe               = (state_ff == ST_EMIT);
      rsp_word.representative  = best_ff;
      rsp_word.tie_count       = ties_ff;
      rsp_word.sym_index       = (ties_ff == '0) ? '0 : tie_rd_ff;
      rsp_word.last            = (emit_ff + 6'd1 >= ties_ff) || (ties_ff == '0);
   end

   // result only while the block is busy
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe outside a query");
   // last result always returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last |=> !busy)
      else $error("block stayed busy after last word");
   // tie count never exceeds MaxSyms
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_word.tie_count <= 6'(MaxSyms))
      else $error("tie count out of range");
endmodule
`default_nettype wire
